### hw/rtl/tlpab_pkg.sv
// Package for the torque limited path acceleration bounds block.
// Holds payload structs, register and mode codes, FSM states and helpers.
// No dependencies.
`default_nettype none
package tlpab_pkg;

  localparam int TLPAB_MAX_JOINTS  = 8;
  localparam int TLPAB_MAX_SAMPLES = 1024;
  localparam int TLPAB_FRAC_BITS   = 16;

  localparam int MUL_AW = 33;
  localparam int MUL_BW = 32;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 32;

  localparam logic [1:0] MODE_DYN   = 2'd0;
  localparam logic [1:0] MODE_TRQ   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [2:0] REG_DOF_COUNT    = 3'd0;
  localparam logic [2:0] REG_SAMPLE_STEP  = 3'd1;
  localparam logic [2:0] REG_LAST_SAMPLE  = 3'd2;
  localparam logic [2:0] REG_PATH_LENGTH  = 3'd3;
  localparam logic [2:0] REG_SAFETY_BOUND = 3'd4;
  localparam logic [2:0] REG_TINY         = 3'd5;

  typedef struct packed {
    logic        [1:0]  mode;
    logic        [9:0]  sample_index;
    logic        [2:0]  joint_index;
    logic signed [31:0] coef_inertia;
    logic signed [31:0] coef_velocity;
    logic signed [31:0] coef_gravity;
    logic signed [31:0] torque_low;
    logic signed [31:0] torque_high;
    logic signed [31:0] path_pos;
    logic signed [31:0] path_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] accel_low;
    logic signed [31:0] accel_high;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  dof_count;
    logic [30:0] sample_step;
    logic [9:0]  last_sample;
    logic [30:0] path_length;
    logic [30:0] safety_bound;
    logic [15:0] tiny_threshold;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
    logic [DIV_DW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_POS_DIV, ST_POS_WAIT, ST_SQ_MUL, ST_SQ_WB,
    ST_RD0, ST_RD1, ST_RD2, ST_L_MUL, ST_L_DIV, ST_L_WAIT,
    ST_CHK, ST_B_MUL, ST_B_WB, ST_D_LO, ST_W_LO, ST_D_HI, ST_W_HI,
    ST_NEXT, ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tlpab_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on tlpab_pkg.
`default_nettype none
module tlpab_mul
  import tlpab_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic [MUL_AW-1:0]        a,
  input  wire logic [MUL_BW-1:0]        b,
  output logic      [MUL_AW+MUL_BW-1:0] p
);

  logic [MUL_AW+MUL_BW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule
`default_nettype wire

### hw/rtl/tlpab_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on tlpab_pkg.
`default_nettype none
module tlpab_div
  import tlpab_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CW = $clog2(DIV_NW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dsr_r, dsr_nxt;
  logic [DIV_DW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[DIV_NW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp = '{done: done_r, quotient: quo_r, remainder: rem_r};

endmodule
`default_nettype wire

### hw/rtl/tlpab_seq.sv
// Sequencer with coefficient memory and torque tables; drives the shared
// multiplier and divider. Depends on tlpab_pkg.
`default_nettype none
module tlpab_seq
  import tlpab_pkg::*;
#(
  parameter int MAX_JOINTS  = TLPAB_MAX_JOINTS,
  parameter int MAX_SAMPLES = TLPAB_MAX_SAMPLES,
  parameter int FRAC_BITS   = TLPAB_FRAC_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     start,
  input  wire in_item_t                 in_data,
  output logic                          busy,
  output logic                          out_valid,
  output out_item_t                     out_data,
  output logic [MUL_AW-1:0]             mul_a,
  output logic [MUL_BW-1:0]             mul_b,
  input  wire logic [MUL_AW+MUL_BW-1:0] mul_p,
  output div_req_t                      div_req,
  input  wire div_rsp_t                 div_rsp
);

  localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int JCW   = $clog2(MAX_JOINTS + 1);
  localparam int SW    = $clog2(MAX_SAMPLES);
  localparam int DEPTH = MAX_SAMPLES * MAX_JOINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [63:0] LIM = (64'sd1 <<< (62 - FRAC_BITS)) - 64'sd1;
  localparam logic [63:0] RND = (64'd1 << FRAC_BITS) - 64'd1;

  state_t state_r, state_nxt;

  logic [95:0]          mem [DEPTH];
  logic [95:0]          rd_q;
  logic [AW-1:0]        raddr;
  logic signed [31:0]   tmin_r [MAX_JOINTS];
  logic signed [31:0]   tmax_r [MAX_JOINTS];

  logic [30:0]          s_r, step_r, rem_r, sq_r;
  logic [31:0]          vmag_r;
  logic                 end_r, interp_r;
  logic [SW-1:0]        last_r, n_r;
  logic [JCW-1:0]       dofs_r, j_r;
  logic [1:0]           k_r;
  logic signed [31:0]   p0_r [3];
  logic signed [31:0]   p1_r [3];
  logic signed [31:0]   co_r [3];
  logic signed [63:0]   nlo_r, nhi_r;
  logic signed [31:0]   alpha_r, beta_r;

  logic                 acc;
  logic signed [31:0]   rd_w [3];
  logic signed [32:0]   diff;
  logic [32:0]          dmag;
  logic [31:0]          amag, bmag;
  logic                 skip;
  logic [JW-1:0]        jx;
  logic signed [31:0]   tlo, thi;
  logic [63:0]          pm;
  logic signed [63:0]   prod, nlo, nhi;
  logic [63:0]          nlo_mag, nhi_mag;
  logic signed [63:0]   qs;
  logic signed [33:0]   lsum;
  logic [64:0]          sqf;
  logic [4:0]           dofc;

  assign acc  = start && (state_r == ST_IDLE);
  assign busy = (state_r != ST_IDLE);
  assign jx   = j_r[JW-1:0];

  assign rd_w[0] = rd_q[95:64];
  assign rd_w[1] = rd_q[63:32];
  assign rd_w[2] = rd_q[31:0];

  assign diff = {p1_r[k_r][31], p1_r[k_r]} - {p0_r[k_r][31], p0_r[k_r]};
  assign dmag = diff[32] ? 33'(-diff) : 33'(diff);
  assign amag = co_r[0][31] ? 32'(-co_r[0]) : 32'(co_r[0]);
  assign bmag = co_r[1][31] ? 32'(-co_r[1]) : 32'(co_r[1]);
  assign skip = (co_r[0] == 32'sd0) || (amag < {16'd0, cfg.tiny_threshold});
  assign tlo  = co_r[0][31] ? tmax_r[jx] : tmin_r[jx];
  assign thi  = co_r[0][31] ? tmin_r[jx] : tmax_r[jx];
  assign pm   = mul_p[63:0];
  assign prod = co_r[1][31] ? -$signed((pm + RND) >> FRAC_BITS)
                            : $signed(pm >> FRAC_BITS);
  assign nlo  = 64'(tlo) - prod - 64'(co_r[2]);
  assign nhi  = 64'(thi) - prod - 64'(co_r[2]);
  assign nlo_mag = nlo_r[63] ? 64'(-nlo_r) : 64'(nlo_r);
  assign nhi_mag = nhi_r[63] ? 64'(-nhi_r) : 64'(nhi_r);
  assign sqf  = mul_p >> FRAC_BITS;
  assign dofc = ({1'b0, cfg.dof_count} < 5'(MAX_JOINTS)) ? {1'b0, cfg.dof_count}
                                                          : 5'(MAX_JOINTS);
  assign lsum = 34'(p0_r[k_r]) + (diff[32] ? -$signed({1'b0, div_rsp.quotient[32:0]})
                                           : $signed({1'b0, div_rsp.quotient[32:0]}));

  always_comb begin
    if ((state_r == ST_W_LO) ? (nlo_r[63] ^ co_r[0][31]) : (nhi_r[63] ^ co_r[0][31]))
      qs = -$signed(div_rsp.quotient);
    else
      qs = $signed(div_rsp.quotient);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (start && in_data.mode == MODE_QUERY) state_nxt = ST_POS_DIV;
      ST_POS_DIV:  state_nxt = ST_POS_WAIT;
      ST_POS_WAIT: if (div_rsp.done) state_nxt = ST_SQ_MUL;
      ST_SQ_MUL:   state_nxt = ST_SQ_WB;
      ST_SQ_WB:    state_nxt = (dofs_r == '0) ? ST_DONE : ST_RD0;
      ST_RD0:      state_nxt = ST_RD1;
      ST_RD1:      state_nxt = interp_r ? ST_RD2 : ST_CHK;
      ST_RD2:      state_nxt = ST_L_MUL;
      ST_L_MUL:    state_nxt = ST_L_DIV;
      ST_L_DIV:    state_nxt = ST_L_WAIT;
      ST_L_WAIT:   if (div_rsp.done) state_nxt = (k_r == 2'd2) ? ST_CHK : ST_L_MUL;
      ST_CHK:      state_nxt = skip ? ST_NEXT : ST_B_MUL;
      ST_B_MUL:    state_nxt = ST_B_WB;
      ST_B_WB:     state_nxt = ST_D_LO;
      ST_D_LO:     state_nxt = ST_W_LO;
      ST_W_LO:     if (div_rsp.done) state_nxt = ST_D_HI;
      ST_D_HI:     state_nxt = ST_W_HI;
      ST_W_HI:     if (div_rsp.done) state_nxt = ST_NEXT;
      ST_NEXT:     state_nxt = (JCW'(j_r + 1'b1) == dofs_r) ? ST_DONE : ST_RD0;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    raddr     = AW'(32'(n_r) * MAX_JOINTS + 32'(j_r));
    out_valid = 1'b0;
    unique case (state_r)
      ST_POS_DIV: begin
        div_req = '{start: 1'b1, dividend: {33'd0, s_r}, divisor: {1'b0, step_r}};
      end
      ST_SQ_MUL: begin
        mul_a = {1'b0, vmag_r};
        mul_b = vmag_r;
      end
      ST_RD1: begin
        raddr = AW'((32'(n_r) + 32'd1) * MAX_JOINTS + 32'(j_r));
      end
      ST_L_MUL: begin
        mul_a = dmag;
        mul_b = {1'b0, rem_r};
      end
      ST_L_DIV: begin
        div_req = '{start: 1'b1, dividend: pm, divisor: {1'b0, step_r}};
      end
      ST_B_MUL: begin
        mul_a = {2'b0, sq_r};
        mul_b = bmag;
      end
      ST_D_LO: begin
        div_req = '{start: 1'b1, dividend: nlo_mag << FRAC_BITS, divisor: amag};
      end
      ST_D_HI: begin
        div_req = '{start: 1'b1, dividend: nhi_mag << FRAC_BITS, divisor: amag};
      end
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_data = '{accel_low: alpha_r, accel_high: beta_r};

  always_ff @(posedge clk) begin
    if (acc && in_data.mode == MODE_DYN &&
        {7'd0, in_data.sample_index} < 17'(MAX_SAMPLES) &&
        {2'd0, in_data.joint_index} < 5'(MAX_JOINTS)) begin
      mem[AW'(32'(in_data.sample_index) * MAX_JOINTS + 32'(in_data.joint_index))] <=
        {in_data.coef_inertia, in_data.coef_velocity, in_data.coef_gravity};
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.mode == MODE_TRQ && {2'd0, in_data.joint_index} < 5'(MAX_JOINTS)) begin
      tmin_r[JW'(in_data.joint_index)] <= in_data.torque_low;
      tmax_r[JW'(in_data.joint_index)] <= in_data.torque_high;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        s_r      <= in_data.path_pos[31] ? 31'd0 : in_data.path_pos[30:0];
        vmag_r   <= in_data.path_speed[31] ? 32'(-in_data.path_speed)
                                           : 32'(in_data.path_speed);
        step_r   <= (cfg.sample_step == '0) ? 31'd1 : cfg.sample_step;
        last_r   <= ({7'd0, cfg.last_sample} < 17'(MAX_SAMPLES)) ? SW'(cfg.last_sample)
                                                                 : SW'(MAX_SAMPLES - 1);
        dofs_r   <= JCW'(dofc);
        end_r    <= $signed({2'b0, (in_data.path_pos[31] ? 31'd0 : in_data.path_pos[30:0])}) >=
                    $signed({2'b0, cfg.path_length}) - $signed({17'd0, cfg.tiny_threshold});
        alpha_r  <= -$signed({1'b0, cfg.safety_bound});
        beta_r   <= $signed({1'b0, cfg.safety_bound});
        j_r      <= '0;
      end
      ST_POS_WAIT: begin
        if (div_rsp.done) begin
          rem_r <= div_rsp.remainder[30:0];
          if (end_r || div_rsp.quotient >= 64'(last_r)) begin
            n_r      <= last_r;
            interp_r <= 1'b0;
          end else begin
            n_r      <= SW'(div_rsp.quotient);
            interp_r <= div_rsp.remainder[30:0] > {15'd0, cfg.tiny_threshold};
          end
        end
      end
      ST_SQ_WB: sq_r <= (sqf > 65'h7fffffff) ? 31'h7fffffff : sqf[30:0];
      ST_RD1: begin
        for (int k = 0; k < 3; k++) begin
          p0_r[k] <= rd_w[k];
          co_r[k] <= rd_w[k];
        end
        k_r <= 2'd0;
      end
      ST_RD2: begin
        for (int k = 0; k < 3; k++) p1_r[k] <= rd_w[k];
      end
      ST_L_WAIT: begin
        if (div_rsp.done) begin
          co_r[k_r] <= lsum[31:0];
          k_r       <= k_r + 2'd1;
        end
      end
      ST_B_WB: begin
        nlo_r <= (nlo > LIM) ? LIM : ((nlo < -LIM) ? -LIM : nlo);
        nhi_r <= (nhi > LIM) ? LIM : ((nhi < -LIM) ? -LIM : nhi);
      end
      ST_W_LO: if (div_rsp.done && sat32(qs) > alpha_r) alpha_r <= sat32(qs);
      ST_W_HI: if (div_rsp.done && sat32(qs) < beta_r) beta_r <= sat32(qs);
      ST_NEXT: j_r <= JCW'(j_r + 1'b1);
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/torque_limited_path_accel_bounds.sv
// Load items are taken while idle and give no result. A query divides the position by the
// step, squares the speed, then per joint in use reads the table, interpolates if needed
// and, unless the joint is skipped, divides for both bounds in the 64-step shared divider.
// busy is high after the query transfer through the one-cycle strobe, which cannot be
// stalled; the next transfer can be taken in the cycle after it. Synchronous active-low
// reset idles the sequencer, resets the config; coefficient and torque tables are kept.
`default_nettype none
module torque_limited_path_accel_bounds
  import tlpab_pkg::*;
#(
  parameter int MAX_JOINTS  = TLPAB_MAX_JOINTS,
  parameter int MAX_SAMPLES = TLPAB_MAX_SAMPLES,
  parameter int FRAC_BITS   = TLPAB_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t                     cfg_r;
  logic [MUL_AW-1:0]        mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic [MUL_AW+MUL_BW-1:0] mul_p;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dof_count: 4'd1, sample_step: 31'd65536, last_sample: 10'd0,
                 path_length: 31'd0, safety_bound: 31'h7fffffff, tiny_threshold: 16'd1};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DOF_COUNT:    cfg_r.dof_count      <= cfg_data[3:0];
        REG_SAMPLE_STEP:  cfg_r.sample_step    <= cfg_data[30:0];
        REG_LAST_SAMPLE:  cfg_r.last_sample    <= cfg_data[9:0];
        REG_PATH_LENGTH:  cfg_r.path_length    <= cfg_data[30:0];
        REG_SAFETY_BOUND: cfg_r.safety_bound   <= cfg_data[30:0];
        REG_TINY:         cfg_r.tiny_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tlpab_seq #(
    .MAX_JOINTS (MAX_JOINTS),
    .MAX_SAMPLES(MAX_SAMPLES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_p    (mul_p),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  tlpab_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  tlpab_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

endmodule
`default_nettype wire

### hw/rtl/tlpab_chk.sv
// Port-level checker for the top level, attached by bind.
// Depends on tlpab_pkg.
`default_nettype none
module tlpab_chk
  import tlpab_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_data,
  input wire logic      out_valid
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("not idle after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.mode == MODE_QUERY |=> busy)
    else $error("query transfer did not raise busy");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.mode != MODE_QUERY |=> !busy && !out_valid)
    else $error("non-query transfer started work");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 !busy && !out_valid)
    else $error("result strobe not single or not at end of query");

endmodule

bind torque_limited_path_accel_bounds tlpab_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid)
);
`default_nettype wire

### verif/tb.sv
// Testbench for torque_limited_path_accel_bounds: loads dynamics and torque tables,
// sends directed and random queries, and checks each bound pair against an in-bench
// predictor. Depends on tlpab_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb;
  import tlpab_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  torque_limited_path_accel_bounds DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic signed [31:0] inertia_mem  [8192];
  logic signed [31:0] velocity_mem [8192];
  logic signed [31:0] gravity_mem  [8192];
  logic signed [31:0] tmin_mem [8];
  logic signed [31:0] tmax_mem [8];
  cfg_t bench_cfg;

  out_item_t bounds_due[$];
  int mismatches;
  int gap_pct;
  int queries_sent;
  int loads_sent;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] lerp_coef(input longint p0, input longint p1,
                                                   input longint rem, input longint step);
    longint t;
    t = p0 + ((p1 - p0) * rem) / step;
    return t[31:0];
  endfunction

  function automatic void predict_bounds(input in_item_t it, output bit has_res,
                                         output out_item_t res);
    longint s, v, tiny, step, av, sq, lim, alpha, beta, rem, q;
    longint a, b, c, tlo, thi, prod, nlo, nhi;
    int n, last, dofs, k0, k1;
    bit interp;
    has_res = 1'b0;
    res = '0;
    if (it.mode == MODE_DYN) begin
      k0 = int'(it.sample_index) * 8 + int'(it.joint_index);
      inertia_mem[k0]  = it.coef_inertia;
      velocity_mem[k0] = it.coef_velocity;
      gravity_mem[k0]  = it.coef_gravity;
    end else if (it.mode == MODE_TRQ) begin
      tmin_mem[it.joint_index] = it.torque_low;
      tmax_mem[it.joint_index] = it.torque_high;
    end else if (it.mode == MODE_QUERY) begin
      s = longint'(it.path_pos);
      v = longint'(it.path_speed);
      tiny = longint'(bench_cfg.tiny_threshold);
      step = (bench_cfg.sample_step == 0) ? 1 : longint'(bench_cfg.sample_step);
      last = int'(bench_cfg.last_sample);
      dofs = (bench_cfg.dof_count > 8) ? 8 : int'(bench_cfg.dof_count);
      lim = (longint'(1) <<< 46) - 1;
      alpha = -longint'(bench_cfg.safety_bound);
      beta = longint'(bench_cfg.safety_bound);
      rem = 0;
      interp = 1'b0;
      if (s < 0) s = 0;
      if (s >= longint'(bench_cfg.path_length) - tiny) begin
        n = last;
      end else begin
        q = s / step;
        rem = s % step;
        if (q >= last) begin
          n = last;
        end else begin
          n = int'(q);
          interp = rem > tiny;
        end
      end
      av = (v < 0) ? -v : v;
      sq = (av * av) >>> 16;
      if (sq > 64'sd2147483647) sq = 64'sd2147483647;
      for (int j = 0; j < dofs; j++) begin
        k0 = n * 8 + j;
        k1 = (n + 1) * 8 + j;
        if (interp) begin
          a = lerp_coef(inertia_mem[k0], inertia_mem[k1], rem, step);
          b = lerp_coef(velocity_mem[k0], velocity_mem[k1], rem, step);
          c = lerp_coef(gravity_mem[k0], gravity_mem[k1], rem, step);
        end else begin
          a = inertia_mem[k0];
          b = velocity_mem[k0];
          c = gravity_mem[k0];
        end
        if (a == 0 || ((a < 0) ? -a : a) < tiny) continue;
        if (a > 0) begin
          tlo = tmin_mem[j];
          thi = tmax_mem[j];
        end else begin
          tlo = tmax_mem[j];
          thi = tmin_mem[j];
        end
        prod = (sq * b) >>> 16;
        nlo = tlo - prod - c;
        nhi = thi - prod - c;
        if (nlo > lim) nlo = lim;
        if (nlo < -lim) nlo = -lim;
        if (nhi > lim) nhi = lim;
        if (nhi < -lim) nhi = -lim;
        nlo = clip32((nlo * 65536) / a);
        nhi = clip32((nhi * 65536) / a);
        if (nlo > alpha) alpha = nlo;
        if (nhi < beta) beta = nhi;
      end
      res.accel_low = alpha[31:0];
      res.accel_high = beta[31:0];
      has_res = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (bounds_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result low=%0d high=%0d",
                                       out_data.accel_low, out_data.accel_high);
      end else begin
        out_item_t e;
        e = bounds_due.pop_front();
        if (out_data.accel_low !== e.accel_low || out_data.accel_high !== e.accel_high) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bounds mismatch: expected low=%0d high=%0d, got low=%0d high=%0d",
                     e.accel_low, e.accel_high, out_data.accel_low, out_data.accel_high);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it);
    bit has_res;
    out_item_t res;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    predict_bounds(it, has_res, res);
    if (has_res) begin
      bounds_due = {bounds_due, res};
      queries_sent++;
    end else begin
      loads_sent++;
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (bounds_due.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DOF_COUNT:    bench_cfg.dof_count = val[3:0];
      REG_SAMPLE_STEP:  bench_cfg.sample_step = val[30:0];
      REG_LAST_SAMPLE:  bench_cfg.last_sample = val[9:0];
      REG_PATH_LENGTH:  bench_cfg.path_length = val[30:0];
      REG_SAFETY_BOUND: bench_cfg.safety_bound = val[30:0];
      REG_TINY:         bench_cfg.tiny_threshold = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 21) - (1 << 20);
      default: return $urandom_range(0, 1 << 25) - (1 << 24);
    endcase
  endfunction

  task automatic load_dyn(input int si, input int j, input logic [31:0] a,
                          input logic [31:0] b, input logic [31:0] c);
    in_item_t it;
    it = in_item_t'({15'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom});
    it.mode = MODE_DYN;
    it.sample_index = si[9:0];
    it.joint_index = j[2:0];
    it.coef_inertia = a;
    it.coef_velocity = b;
    it.coef_gravity = c;
    send_item(it);
  endtask

  task automatic load_trq(input int j, input logic [31:0] lo, input logic [31:0] hi);
    in_item_t it;
    it = in_item_t'({15'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom});
    it.mode = MODE_TRQ;
    it.joint_index = j[2:0];
    it.torque_low = lo;
    it.torque_high = hi;
    send_item(it);
  endtask

  task automatic query(input logic [31:0] pos, input logic [31:0] spd);
    in_item_t it;
    it = in_item_t'({15'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom});
    it.mode = MODE_QUERY;
    it.path_pos = pos;
    it.path_speed = spd;
    send_item(it);
  endtask

  task automatic test_table_fill;
    for (int si = 0; si < 16; si++)
      for (int j = 0; j < 8; j++) load_dyn(si, j, rnd_word(), rnd_word(), rnd_word());
    for (int j = 0; j < 8; j++) load_trq(j, rnd_word(), rnd_word());
  endtask

  task automatic test_directed;
    in_item_t it;
    load_dyn(0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    load_dyn(1, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    load_dyn(2, 1, 32'sh0, 32'sh10000, 32'sh10000);
    load_trq(0, 32'sh80000000, 32'sh7fffffff);
    write_reg(REG_DOF_COUNT, 32'd2);
    write_reg(REG_LAST_SAMPLE, 32'd7);
    write_reg(REG_PATH_LENGTH, 32'h0010_0000);
    query(32'sh80000000, 32'sh80000000);
    query(32'h0, 32'sh7fffffff);
    query(32'h0001_0000, 32'h0001_8000);
    query(32'h0000_8000, 32'hffff_0000);
    query(32'h0002_0001, 32'h0);
    query(32'h000f_ffff, 32'h0002_0000);
    query(32'h7fffffff, 32'h0001_0000);
    it = in_item_t'({15'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom});
    it.mode = 2'd3;
    send_item(it);
    write_reg(REG_DOF_COUNT, 32'd0);
    query(32'h0001_4000, 32'h0001_0000);
    write_reg(REG_DOF_COUNT, 32'hffff_ffff);
    write_reg(REG_SAMPLE_STEP, 32'h0);
    query(32'h3, 32'h0001_0000);
    write_reg(REG_SAMPLE_STEP, 32'h7fff_ffff);
    write_reg(REG_TINY, 32'h0);
    query(32'h0100_0000, 32'h0003_0000);
    write_reg(REG_TINY, 32'hffff);
    write_reg(REG_SAFETY_BOUND, 32'h0);
    query(32'h0000_0100, 32'h0000_8000);
    write_reg(REG_SAFETY_BOUND, 32'hffff_ffff);
    write_reg(REG_PATH_LENGTH, 32'h7fff_ffff);
    query(32'h7fff_ffff, 32'h0000_4000);
  endtask

  task automatic test_last_sample_extreme;
    for (int j = 0; j < 8; j++) load_dyn(1023, j, rnd_word(), rnd_word(), rnd_word());
    write_reg(REG_LAST_SAMPLE, 32'd1023);
    write_reg(REG_SAMPLE_STEP, 32'h0001_0000);
    write_reg(REG_PATH_LENGTH, 32'h0400_0000);
    write_reg(REG_TINY, 32'h10);
    write_reg(REG_DOF_COUNT, 32'd8);
    query(32'h0400_0000, 32'h0001_0000);
    query(32'h0003_8000, 32'h0001_0000);
    query(32'h0000_0008, $urandom);
  endtask

  task automatic random_config;
    logic [31:0] stepv;
    write_reg(REG_DOF_COUNT, ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 4));
    stepv = ($urandom_range(5) == 0) ? $urandom : $urandom_range(1 << 12, 1 << 18);
    write_reg(REG_SAMPLE_STEP, stepv);
    write_reg(REG_LAST_SAMPLE, $urandom_range(0, 15));
    write_reg(REG_PATH_LENGTH, ($urandom_range(3) == 0) ? $urandom
              : bench_cfg.sample_step * $urandom_range(0, 16));
    write_reg(REG_SAFETY_BOUND, ($urandom_range(3) == 0) ? $urandom
              : $urandom_range(0, 1 << 28));
    write_reg(REG_TINY, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 64));
  endtask

  task automatic test_random(input int items, input int pct);
    logic [31:0] pos;
    in_item_t it;
    gap_pct = pct;
    random_config();
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(9))
        0, 1, 2: load_dyn(($urandom_range(9) == 0) ? $urandom_range(16, 1022)
                          : $urandom_range(0, 15), $urandom_range(0, 7),
                          rnd_word(), rnd_word(), rnd_word());
        3: load_trq($urandom_range(0, 7), rnd_word(), rnd_word());
        4: begin
          it = in_item_t'({15'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom});
          send_item(it);
        end
        default: begin
          pos = ($urandom_range(4) == 0) ? $urandom
                : $urandom_range(0, 17) * bench_cfg.sample_step
                  + $urandom_range(0, bench_cfg.sample_step) - 32'd256;
          query(pos, rnd_word());
        end
      endcase
      if (it.mode == MODE_DYN && it.sample_index >= 16 && it.sample_index != 1023) it = '0;
    end
  endtask

  task automatic test_pause_for_results;
    gap_pct = 0;
    query(32'h0001_0000, 32'h0002_0000);
    drain();
    query(32'h0000_0000, 32'h0001_0000);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DOF_COUNT;
    cfg_data <= '0;
    bench_cfg.dof_count = 4'd1;
    bench_cfg.sample_step = 31'd65536;
    bench_cfg.last_sample = 10'd0;
    bench_cfg.path_length = 31'd0;
    bench_cfg.safety_bound = 31'h7fffffff;
    bench_cfg.tiny_threshold = 16'd1;
    mismatches = 0;
    gap_pct = 0;
    queries_sent = 0;
    loads_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_directed();
    test_last_sample_extreme();
    test_pause_for_results();
    test_random(100, 0);
    test_random(100, 53);
    test_random(100, 18);
    test_random(84, 0);
    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d table loads and %0d bound queries over several register settings",
             loads_sent, queries_sent);
    if (mismatches == 0 && bounds_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
